/* rtl/core/mfs_pkg.sv */
// Shared types and constants of the perceptron inference block.
// Holds the item layout, the structs passed between front and back end and the sigmoid table builder.
package mfs_pkg;

	localparam int MAX_LAYERS_DEF  = 8;
	localparam int MAX_NEURONS_DEF = 64;
	localparam int SIG_SIZE        = 1024;
	localparam int SIG_MID         = SIG_SIZE / 2;
	localparam int FIFO_DEPTH      = 4;
	// ln(e) * 1e9 for the rounded base 2.71828
	localparam logic [63:0] LN_E_SCALED = 64'd999999327;
	// step of the exponent series, 16/SIG_SIZE * ln(e) in Q30
	localparam logic [63:0] SIG_H = ((64'd16 << 30) * LN_E_SCALED) /
	                                (64'(SIG_SIZE) * 64'd1000000000);

	typedef enum logic [1:0] {
		OP_WEIGHT = 2'd0,
		OP_BIAS   = 2'd1,
		OP_INPUT  = 2'd2,
		OP_RUN    = 2'd3
	} op_t;

	typedef enum logic {
		CFG_LAYER_COUNT = 1'b0,
		CFG_LAYER_SIZES = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		op_t                op;
		logic [2:0]         layer;
		logic [5:0]         neuron;
		logic [5:0]         source;
		logic signed [23:0] value;
	} mfs_item_t;

	typedef struct packed {
		logic      valid;
		mfs_item_t item;
	} mfs_head_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} mfs_ctrl_t;

	typedef logic [16:0] sig_word_t;
	typedef sig_word_t sig_tab_t [SIG_SIZE+1];

	// Restoring long division, only ever run at elaboration.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
		logic [63:0] quo;
		logic [63:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= dvs) begin
				rem    = rem - dvs;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Sigmoid samples over [-8,8], end points included, built at elaboration.
	function automatic sig_tab_t sig_build();
		sig_tab_t           tab;
		sig_tab_t           pos;
		logic [63:0]        term;
		logic [63:0]        p;
		logic [63:0]        den;
		logic signed [63:0] r;
		term = 64'd1 << 30;
		r    = 64'sd1 << 30;
		p    = 64'd1 << 30;
		for (int k = 1; k <= 20; k++) begin
			term = udiv64((term * SIG_H) >> 30, 64'(k));
			if (k[0]) r = r - $signed(term);
			else r = r + $signed(term);
		end
		if (r < 0) r = 0;
		for (int k = 0; k <= SIG_SIZE; k++) begin
			if (k > 0) p = (p * 64'(r) + (64'd1 << 29)) >> 30;
			den    = (64'd1 << 30) + p;
			pos[k] = 17'(udiv64((64'd1 << 46) + (den >> 1), den));
		end
		for (int k = 0; k <= SIG_SIZE; k++) begin
			if (k >= SIG_MID) tab[k] = pos[k-SIG_MID];
			else tab[k] = 17'd65536 - pos[SIG_MID-k];
		end
		return tab;
	endfunction

endpackage

/* rtl/core/mfs_front.sv */
// Front end: takes item transfers, drops loads that address nothing, queues the rest.
// Depends on mfs_pkg.
module mfs_front #(
	parameter int MAX_LAYERS  = mfs_pkg::MAX_LAYERS_DEF,
	parameter int MAX_NEURONS = mfs_pkg::MAX_NEURONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mfs_pkg::mfs_item_t in_item,
	input  mfs_pkg::mfs_ctrl_t ctrl,
	output mfs_pkg::mfs_head_t head
);
	import mfs_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	mfs_item_t      fifo_q [FIFO_DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;
	logic           keep;
	logic           push;

	always_comb begin
		unique case (in_item.op)
			OP_WEIGHT: keep = (in_item.layer != 3'd0) && (32'(in_item.layer) < MAX_LAYERS) &&
			                  (32'(in_item.neuron) < MAX_NEURONS) &&
			                  (32'(in_item.source) < MAX_NEURONS);
			OP_BIAS:   keep = (32'(in_item.layer) < MAX_LAYERS) &&
			                  (32'(in_item.neuron) < MAX_NEURONS);
			OP_INPUT:  keep = 32'(in_item.neuron) < MAX_NEURONS;
			OP_RUN:    keep = 1'b1;
			default:   keep = 1'b0;
		endcase
	end

	assign in_ready = (32'(count_q) < FIFO_DEPTH) && !ctrl.clearing;
	assign push     = in_valid && in_ready && keep;

	always_ff @(posedge clk) begin
		if (push) fifo_q[wptr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + PW'(1);
			if (ctrl.pop) rptr_q <= rptr_q + PW'(1);
			if (push && !ctrl.pop) count_q <= count_q + CW'(1);
			else if (!push && ctrl.pop) count_q <= count_q - CW'(1);
		end
	end

	assign head.valid = count_q != '0;
	assign head.item  = fifo_q[rptr_q];

endmodule

/* rtl/core/mfs_sigmoid.sv */
// Table sigmoid with linear interpolation, three register stages.
// Depends on mfs_pkg for the table contents.
module mfs_sigmoid (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_vld,
	input  logic signed [23:0] s,
	output logic               res_vld,
	output logic [16:0]        res
);
	import mfs_pkg::*;

	localparam int IW = $clog2(SIG_SIZE + 1);
	localparam int UW = 20 + IW;
	localparam sig_tab_t SIG_TABLE = sig_build();

	logic signed [24:0] t;
	logic [UW-1:0]      u;
	logic [IW-1:0]      idx;
	logic [IW-1:0]      idx_p1;
	logic               below;
	logic               above;

	logic [16:0] lo_s1, hi_s1;
	logic [19:0] frac_s1;
	logic        below_s1, above_s1, vld_s1;
	logic [16:0] diff;
	logic [36:0] prod_s2;
	logic [16:0] lo_s2;
	logic        below_s2, above_s2, vld_s2;
	logic [16:0] res_s3;
	logic        vld_s3;

	assign t      = 25'(s) + 25'sd524288;
	assign below  = s < -24'sd524288;
	assign above  = s >= 24'sd524288;
	assign u      = UW'(t[19:0]) * UW'(SIG_SIZE);
	assign idx    = u[UW-1:20];
	assign idx_p1 = idx + IW'(1);

	always_ff @(posedge clk) begin
		lo_s1    <= SIG_TABLE[idx];
		hi_s1    <= SIG_TABLE[idx_p1];
		frac_s1  <= u[19:0];
		below_s1 <= below;
		above_s1 <= above;
	end

	assign diff = (hi_s1 > lo_s1) ? hi_s1 - lo_s1 : 17'd0;

	always_ff @(posedge clk) begin
		prod_s2  <= 37'(diff) * 37'(frac_s1);
		lo_s2    <= lo_s1;
		below_s2 <= below_s1;
		above_s2 <= above_s1;
		if (below_s2) res_s3 <= 17'd0;
		else if (above_s2) res_s3 <= 17'd65536;
		else res_s3 <= lo_s2 + 17'(prod_s2 >> 20);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= s_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign res_vld = vld_s3;
	assign res     = res_s3;

endmodule

/* rtl/core/mfs_engine.sv */
// Back end: weight, bias and neuron stores, layer sequencer, MAC pipeline and result register.
// Depends on mfs_pkg and mfs_sigmoid.
module mfs_engine #(
	parameter int MAX_LAYERS  = mfs_pkg::MAX_LAYERS_DEF,
	parameter int MAX_NEURONS = mfs_pkg::MAX_NEURONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  mfs_pkg::cfg_reg_t  cfg_sel,
	input  logic [55:0]        cfg_data,
	input  mfs_pkg::mfs_head_t head,
	output mfs_pkg::mfs_ctrl_t ctrl,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         out_index,
	output logic signed [23:0] out_value,
	output logic               last
);
	import mfs_pkg::*;

	localparam int NB        = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
	localparam int LB        = $clog2(MAX_LAYERS);
	localparam int OUT_LIMIT = (MAX_NEURONS < 64) ? MAX_NEURONS : 64;
	localparam int WDEPTH    = (MAX_LAYERS - 1) * (2 ** (2 * NB));
	localparam int WAW       = $clog2(WDEPTH);
	localparam int NDEPTH    = MAX_LAYERS * (2 ** NB);
	localparam int NAW       = $clog2(NDEPTH);
	localparam logic signed [53:0] QMAX = 54'sd8388607;
	localparam logic signed [53:0] QMIN = -54'sd8388608;

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_LAYER = 9'b000000100,
		ST_MAC   = 9'b000001000,
		ST_WAIT  = 9'b000010000,
		ST_SIGM  = 9'b000100000,
		ST_BIAS  = 9'b001000000,
		ST_OUTRD = 9'b010000000,
		ST_OUTWR = 9'b100000000
	} state_t;

	function automatic logic signed [23:0] sat24(input logic signed [53:0] v);
		if (v > QMAX) return 24'sd8388607;
		if (v < QMIN) return -24'sd8388608;
		return v[23:0];
	endfunction

	function automatic logic [6:0] size_of(input logic [55:0] sizes, input logic [3:0] l);
		logic [6:0] sz;
		if (l[3]) return 7'd0;
		sz = sizes[7*l[2:0] +: 7];
		if (32'(sz) > OUT_LIMIT) sz = 7'(OUT_LIMIT);
		return sz;
	endfunction

	state_t             state_q;
	logic [3:0]         lcount_q;
	logic [55:0]        lsizes_q;
	logic [WAW-1:0]     clr_q;
	logic [3:0]         l_q;
	logic [6:0]         j_q;
	logic [6:0]         k_q;
	logic [3:0]         lc;
	logic [6:0]         cur, prev, outn;

	logic signed [23:0] weight_mem [WDEPTH];
	logic signed [23:0] bias_mem   [NDEPTH];
	logic signed [23:0] neuron_mem [NDEPTH];

	logic               w_we, b_we, n_we;
	logic [WAW-1:0]     w_wa, w_ra;
	logic [NAW-1:0]     b_wa, b_ra, n_wa, n_ra;
	logic signed [23:0] w_wd, b_wd, n_wd;
	logic signed [23:0] wrd_q, brd_q, nrd_q;

	logic               mac_vld_s1, mac_last_s1;
	logic               mac_vld_s2, mac_last_s2;
	logic signed [47:0] prod_s2;
	logic signed [53:0] acc_q;
	logic signed [53:0] qsum;
	logic signed [53:0] bsum;

	logic               sig_vld;
	logic [16:0]        sig_res;
	logic               clearing;
	logic               clr_nb;
	logic               pop;
	logic               out_load;
	logic               out_last;

	logic               out_valid_q;
	logic [5:0]         out_index_q;
	logic signed [23:0] out_value_q;
	logic               out_last_q;

	assign clearing = state_q == ST_CLEAR;
	assign clr_nb   = 32'(clr_q) < NDEPTH;
	assign pop      = (state_q == ST_IDLE) && head.valid;
	assign ctrl     = '{pop: pop, clearing: clearing};

	always_comb begin
		if (lcount_q < 4'd2) lc = 4'd2;
		else if (32'(lcount_q) > MAX_LAYERS) lc = 4'(MAX_LAYERS);
		else lc = lcount_q;
	end

	assign cur      = size_of(lsizes_q, l_q);
	assign prev     = size_of(lsizes_q, l_q - 4'd1);
	assign outn     = size_of(lsizes_q, lc - 4'd1);
	assign out_load = (state_q == ST_OUTWR) && (!out_valid_q || out_ready);
	assign out_last = (j_q + 7'd1) == outn;

	// store ports
	always_comb begin
		w_we = clearing || (pop && head.item.op == OP_WEIGHT);
		w_wa = clearing ? clr_q
		                : WAW'({LB'(head.item.layer - 3'd1), NB'(head.item.neuron),
		                        NB'(head.item.source)});
		w_wd = clearing ? 24'sd0 : head.item.value;
		w_ra = WAW'({LB'(l_q - 4'd1), NB'(j_q), NB'(k_q)});

		b_we = (clearing && clr_nb) || (pop && head.item.op == OP_BIAS);
		b_wa = clearing ? clr_q[NAW-1:0]
		                : NAW'({LB'(head.item.layer), NB'(head.item.neuron)});
		b_wd = clearing ? 24'sd0 : head.item.value;
		b_ra = NAW'({LB'(l_q), NB'(j_q)});

		bsum = 54'($signed({1'b0, sig_res})) + 54'(brd_q);
		n_we = (clearing && clr_nb) || (pop && head.item.op == OP_INPUT) ||
		       (state_q == ST_BIAS && sig_vld);
		if (clearing) begin
			n_wa = clr_q[NAW-1:0];
			n_wd = 24'sd0;
		end else if (state_q == ST_BIAS) begin
			n_wa = NAW'({LB'(l_q), NB'(j_q)});
			n_wd = sat24(bsum);
		end else begin
			n_wa = NAW'(NB'(head.item.neuron));
			n_wd = head.item.value;
		end
		if (state_q == ST_MAC) n_ra = NAW'({LB'(l_q - 4'd1), NB'(k_q)});
		else n_ra = NAW'({LB'(lc - 4'd1), NB'(j_q)});
	end

	always_ff @(posedge clk) begin
		if (w_we) weight_mem[w_wa] <= w_wd;
		wrd_q <= weight_mem[w_ra];
	end

	always_ff @(posedge clk) begin
		if (b_we) bias_mem[b_wa] <= b_wd;
		brd_q <= bias_mem[b_ra];
	end

	always_ff @(posedge clk) begin
		if (n_we) neuron_mem[n_wa] <= n_wd;
		nrd_q <= neuron_mem[n_ra];
	end

	// MAC pipeline: read, multiply, accumulate
	always_ff @(posedge clk) begin
		prod_s2 <= nrd_q * wrd_q;
		if (state_q == ST_LAYER) acc_q <= '0;
		else if (mac_vld_s2) acc_q <= acc_q + 54'(prod_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_vld_s1  <= 1'b0;
			mac_last_s1 <= 1'b0;
			mac_vld_s2  <= 1'b0;
			mac_last_s2 <= 1'b0;
		end else begin
			mac_vld_s1  <= state_q == ST_MAC;
			mac_last_s1 <= k_q == prev - 7'd1;
			mac_vld_s2  <= mac_vld_s1;
			mac_last_s2 <= mac_last_s1;
		end
	end

	// floor shift back to Q8.16
	assign qsum = acc_q >>> 16;

	mfs_sigmoid u_sig (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_vld   (state_q == ST_SIGM),
		.s       (sat24(qsum)),
		.res_vld (sig_vld),
		.res     (sig_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcount_q <= 4'd2;
			lsizes_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_sel)
				CFG_LAYER_COUNT: lcount_q <= cfg_data[3:0];
				CFG_LAYER_SIZES: lsizes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			l_q     <= 4'd1;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + WAW'(1);
					if (32'(clr_q) == WDEPTH - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (pop && head.item.op == OP_RUN) begin
						l_q     <= 4'd1;
						j_q     <= '0;
						state_q <= ST_LAYER;
					end
				end
				ST_LAYER: begin
					if (l_q >= lc) begin
						j_q     <= '0;
						state_q <= (outn == 7'd0) ? ST_IDLE : ST_OUTRD;
					end else if (j_q >= cur) begin
						l_q <= l_q + 4'd1;
						j_q <= '0;
					end else begin
						k_q     <= '0;
						state_q <= (prev == 7'd0) ? ST_SIGM : ST_MAC;
					end
				end
				ST_MAC: begin
					k_q <= k_q + 7'd1;
					if (k_q == prev - 7'd1) state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mac_vld_s2 && mac_last_s2) state_q <= ST_SIGM;
				end
				ST_SIGM: state_q <= ST_BIAS;
				ST_BIAS: begin
					if (sig_vld) begin
						j_q     <= j_q + 7'd1;
						state_q <= ST_LAYER;
					end
				end
				ST_OUTRD: state_q <= ST_OUTWR;
				ST_OUTWR: begin
					if (out_load) begin
						j_q     <= j_q + 7'd1;
						state_q <= out_last ? ST_IDLE : ST_OUTRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_index_q <= 6'(j_q);
			out_value_q <= nrd_q;
			out_last_q  <= out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_value = out_value_q;
	assign last      = out_last_q;

	a_mac_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		mac_vld_s2 |-> (state_q == ST_MAC || state_q == ST_WAIT))
		else $error("MAC product outside neuron accumulation");

	a_sig_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sig_vld |-> state_q == ST_BIAS)
		else $error("sigmoid result with no neuron waiting");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_last) |=> state_q == ST_IDLE)
		else $error("run did not end after last result");

	a_clear_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> (state_q == ST_CLEAR || state_q == ST_IDLE))
		else $error("clearing pass left early");

endmodule

/* rtl/core/mlp_forward_sigmoid_top.sv */
// Top level of the perceptron inference block: front queue, execution engine.
// Depends on mfs_pkg, mfs_front and mfs_engine.
//
// Loads (weight, bias, input value) are taken one per cycle while the queue has room, and
// written one per cycle by the engine while idle; a four-entry queue lets loads arrive while
// a run is busy. After reset the stores are zeroed by a clearing pass over the weight store's
// (MAX_LAYERS-1)*2^(2*ceil(log2 MAX_NEURONS)) addresses (28672 at the defaults), during which
// in_ready stays low; configuration writes are still taken. A run walks every neuron of
// layers 1 .. clamped layer_count-1 through one shared multiply-accumulate unit fed from one
// read port per store: a neuron with P inputs gets P MAC issues, pipeline drain, saturation,
// the three-stage sigmoid and bias add; each output value then goes to the result register.
module mlp_forward_sigmoid_top #(
	parameter int MAX_LAYERS  = mfs_pkg::MAX_LAYERS_DEF,
	parameter int MAX_NEURONS = mfs_pkg::MAX_NEURONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [55:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [2:0]         layer_index,
	input  logic [5:0]         neuron_index,
	input  logic [5:0]         source_index,
	input  logic signed [23:0] load_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         out_index,
	output logic signed [23:0] out_value,
	output logic               last
);
	import mfs_pkg::*;

	mfs_item_t in_item;
	mfs_head_t head;
	mfs_ctrl_t ctrl;

	assign in_item = '{op: op_t'(kind), layer: layer_index, neuron: neuron_index,
	                   source: source_index, value: load_value};

	mfs_front #(
		.MAX_LAYERS  (MAX_LAYERS),
		.MAX_NEURONS (MAX_NEURONS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.ctrl     (ctrl),
		.head     (head)
	);

	mfs_engine #(
		.MAX_LAYERS  (MAX_LAYERS),
		.MAX_NEURONS (MAX_NEURONS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_sel   (cfg_reg_t'(cfg_index)),
		.cfg_data  (cfg_data),
		.head      (head),
		.ctrl      (ctrl),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_index (out_index),
		.out_value (out_value),
		.last      (last)
	);

endmodule

/* verif/tb_mlp_forward_sigmoid_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for mlp_forward_sigmoid_top: directed table, then random networks, then the largest network.
// Depends on mfs_pkg and the RTL below rtl/core; holds its own fixed-point network predictor.
module tb_mlp_forward_sigmoid_top;
	import mfs_pkg::*;

	localparam int NL        = 8;
	localparam int NN        = 64;
	localparam int TBL       = 1024;
	localparam int WDOG_MAX  = 100000;
	localparam int SETTLE    = 40;

	typedef struct {
		logic [5:0]         idx;
		logic signed [23:0] val;
		logic               lst;
	} neuron_out_t;

	typedef struct {
		bit                 is_cfg;
		logic [3:0]         count;
		logic [55:0]        sizes;
		op_t                op;
		logic [2:0]         li;
		logic [5:0]         ni;
		logic [5:0]         si;
		logic signed [23:0] val;
		bit                 typed;
		logic signed [23:0] want;
	} plan_row_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_we;
	logic               cfg_index;
	logic [55:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         kind;
	logic [2:0]         layer_index;
	logic [5:0]         neuron_index;
	logic [5:0]         source_index;
	logic signed [23:0] load_value;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [5:0]         out_index;
	logic signed [23:0] out_value;
	logic               last;

	mlp_forward_sigmoid_top uut (.*);

	// predictor state
	int          weight_mem [NL-1][NN][NN];
	int          bias_mem [NL][NN];
	int          act_mem [NL][NN];
	int          sig_lut [TBL+1];
	logic [3:0]  cur_count = 4'd2;
	logic [55:0] cur_sizes = '0;

	neuron_out_t pending_outputs [$];
	plan_row_t   plan [$];
	int          errors = 0;
	int          idle_cycles = 0;
	int          checked = 0;
	int          items_sent = 0;
	int          runs_sent = 0;
	int          tx_idle = 0;
	int          rx_idle = 0;
	// cycles still owed to runs that end without any output
	int          tail_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int sat_q(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return int'(v);
	endfunction

	function automatic void build_lut();
		longint unsigned h, term, p, den;
		longint          r;
		int              pos [TBL+1];
		h    = ((64'd16 << 30) * 64'd999999327) / (64'(TBL) * 64'd1000000000);
		term = 64'd1 << 30;
		r    = 64'sd1 << 30;
		p    = 64'd1 << 30;
		for (int k = 1; k <= 20; k++) begin
			term = ((term * h) >> 30) / 64'(k);
			if (k % 2) r -= longint'(term);
			else r += longint'(term);
		end
		if (r < 0) r = 0;
		for (int k = 0; k <= TBL; k++) begin
			if (k > 0) p = (p * longint'(unsigned'(r)) + (64'd1 << 29)) >> 30;
			den    = (64'd1 << 30) + p;
			pos[k] = int'(((64'd1 << 46) + den / 2) / den);
		end
		for (int k = 0; k <= TBL; k++)
			sig_lut[k] = (k >= TBL/2) ? pos[k - TBL/2] : 65536 - pos[TBL/2 - k];
	endfunction

	function automatic int sigmoid_fx(int s);
		longint unsigned u, frac, diff;
		int              i;
		if (s < -524288) return 0;
		if (s >= 524288) return 65536;
		u    = longint'(s + 524288) * TBL;
		i    = int'(u >> 20);
		frac = u & 64'hFFFFF;
		diff = (sig_lut[i+1] > sig_lut[i]) ? longint'(sig_lut[i+1] - sig_lut[i]) : 0;
		return sig_lut[i] + int'((diff * frac) >> 20);
	endfunction

	function automatic int layer_width(int l);
		int n;
		if (l >= 8) return 0;
		n = int'((cur_sizes >> (7*l)) & 56'h7F);
		return (n > NN) ? NN : n;
	endfunction

	function automatic logic [55:0] lsz(int l, int n);
		return 56'(n) << (7*l);
	endfunction

	// Updates the stores for one accepted item and queues the outputs a run produces.
	task automatic forward_pass(op_t op, logic [2:0] li, logic [5:0] ni, logic [5:0] si,
			logic signed [23:0] v);
		int     lc, cur, prv, outn, est;
		longint acc;
		neuron_out_t o;
		case (op)
			OP_WEIGHT: if (li != 0) weight_mem[li-1][ni][si] = v;
			OP_BIAS:   bias_mem[li][ni] = v;
			OP_INPUT:  act_mem[0][ni] = v;
			OP_RUN: begin
				est = 0;
				lc = (cur_count < 2) ? 2 : (cur_count > NL) ? NL : int'(cur_count);
				for (int l = 1; l < lc; l++) begin
					cur = layer_width(l);
					prv = layer_width(l-1);
					est += cur * (prv + 8) + 2;
					for (int j = 0; j < cur; j++) begin
						acc = 0;
						for (int k = 0; k < prv; k++)
							acc += longint'(act_mem[l-1][k]) * longint'(weight_mem[l-1][j][k]);
						acc = acc >>> 16; // floor
						act_mem[l][j] = sat_q(longint'(sigmoid_fx(sat_q(acc))) + bias_mem[l][j]);
					end
				end
				outn = layer_width(lc-1);
				for (int j = 0; j < outn; j++) begin
					o.idx = 6'(j);
					o.val = 24'(act_mem[lc-1][j]);
					o.lst = (j == outn-1);
					pending_outputs = {pending_outputs, o};
				end
				tail_cycles = (outn == 0) ? tail_cycles + est : 0;
			end
		endcase
	endtask

	// Presents one item and waits for its transfer; in_valid stays high afterwards.
	task automatic send(op_t op, logic [2:0] li, logic [5:0] ni, logic [5:0] si,
			logic signed [23:0] v);
		int gap;
		gap = ($urandom_range(99) < tx_idle) ? $urandom_range(4, 1) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind         <= op;
		layer_index  <= li;
		neuron_index <= ni;
		source_index <= si;
		load_value   <= v;
		in_valid     <= 1'b1;
		do @(posedge clk); while (!in_ready);
		forward_pass(op, li, ni, si, v);
		items_sent++;
		if (op == OP_RUN) runs_sent++;
	endtask

	// Holds the sender back until every queued output has come, then lets loads finish.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE + tail_cycles) @(posedge clk);
		tail_cycles = 0;
	endtask

	task automatic program_net(logic [3:0] cnt, logic [55:0] sizes);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LAYER_COUNT;
		cfg_data  <= 56'(cnt);
		@(posedge clk);
		cfg_index <= CFG_LAYER_SIZES;
		cfg_data  <= sizes;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_count = cnt;
		cur_sizes = sizes;
	endtask

	function automatic logic signed [23:0] rand_q();
		if ($urandom_range(7) == 0) return 24'($urandom);
		return 24'(int'($urandom_range(262143)) - 131072);
	endfunction

	task automatic send_noise();
		send(op_t'($urandom_range(2)), 3'($urandom), 6'($urandom), 6'($urandom), 24'($urandom));
	endtask

	// One random network: configure, load all parameters unless wide, then two to four runs (one if wide).
	task automatic random_net(input bit wide);
		int          lc, w [NL];
		logic [55:0] sz;
		sz = '0;
		lc = $urandom_range(5, 2);
		for (int l = 0; l < NL; l++) begin
			w[l] = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
			sz |= lsz(l, w[l]);
		end
		if (wide) sz = 56'({$urandom, $urandom});
		program_net(4'(lc), sz);
		if (!wide) begin
			for (int l = 1; l < lc; l++)
				for (int j = 0; j < layer_width(l); j++) begin
					send(OP_BIAS, 3'(l), 6'(j), 6'($urandom), rand_q());
					for (int k = 0; k < layer_width(l-1); k++) begin
						if ($urandom_range(9) == 0) send_noise();
						send(OP_WEIGHT, 3'(l), 6'(j), 6'(k), rand_q());
					end
				end
		end
		repeat (wide ? 1 : $urandom_range(4, 2)) begin
			for (int k = 0; k < layer_width(0); k++)
				send(OP_INPUT, 3'($urandom), 6'(k), 6'($urandom), rand_q());
			if ($urandom_range(3) == 0) send_noise();
			send(OP_RUN, 3'($urandom), 6'($urandom), 6'($urandom), 24'($urandom));
		end
	endtask

	function automatic plan_row_t blank_row();
		plan_row_t r;
		r.is_cfg = 1'b0;
		r.count  = '0;
		r.sizes  = '0;
		r.op     = OP_WEIGHT;
		r.li     = '0;
		r.ni     = '0;
		r.si     = '0;
		r.val    = '0;
		r.typed  = 1'b0;
		r.want   = '0;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(logic [3:0] c, logic [55:0] s);
		plan_row_t r;
		r = blank_row();
		r.is_cfg = 1'b1;
		r.count  = c;
		r.sizes  = s;
		return r;
	endfunction

	function automatic plan_row_t item_row(op_t op, int li, int ni, int si, int v,
			bit typed = 0, int want = 0);
		plan_row_t r;
		r = blank_row();
		r.op    = op;
		r.li    = 3'(li);
		r.ni    = 6'(ni);
		r.si    = 6'(si);
		r.val   = 24'(v);
		r.typed = typed;
		r.want  = 24'(want);
		return r;
	endfunction

	function automatic void add_row(plan_row_t r);
		plan = {plan, r};
	endfunction

	// Output checker, receiver stalls and watchdog count.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				checked++;
				if (pending_outputs.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: unexpected output idx=%0d val=%0d last=%0b",
							out_index, out_value, last);
				end else begin
					if (out_index !== pending_outputs[0].idx ||
							out_value !== pending_outputs[0].val ||
							last !== pending_outputs[0].lst) begin
						errors++;
						if (errors <= 10)
							$display("ERROR: output exp idx=%0d val=%0d last=%0b, got %0d %0d %0b",
								pending_outputs[0].idx, pending_outputs[0].val,
								pending_outputs[0].lst, out_index, out_value, last);
					end
					void'(pending_outputs.pop_front());
				end
			end
			idle_cycles <= ((out_valid && out_ready) || (in_valid && in_ready)) ? 0 : idle_cycles + 1;
			out_ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	initial begin
		while (idle_cycles < WDOG_MAX) @(posedge clk);
		$display("ERROR: watchdog expired, %0d outputs outstanding", pending_outputs.size());
		$display("tb_mlp_forward_sigmoid_top: done, errors");
		$finish;
	end

	initial begin
		int phase_items;
		in_valid     <= 1'b0;
		kind         <= OP_WEIGHT;
		layer_index  <= '0;
		neuron_index <= '0;
		source_index <= '0;
		load_value   <= '0;
		cfg_we       <= 1'b0;
		cfg_index    <= CFG_LAYER_COUNT;
		cfg_data     <= '0;
		build_lut();
		foreach (weight_mem[l, j, k]) weight_mem[l][j][k] = 0;
		foreach (bias_mem[l, j]) begin
			bias_mem[l][j] = 0;
			act_mem[l][j]  = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// single empty-fed neuron gives sigmoid(0) + bias, saturated at the top end only
		add_row(cfg_row(4'd2, lsz(1, 1)));
		add_row(item_row(OP_RUN, 0, 0, 0, 0, 1, 32768));
		add_row(item_row(OP_BIAS, 1, 0, 0, 8388607));
		add_row(item_row(OP_RUN, 0, 0, 0, 0, 1, 8388607));
		add_row(item_row(OP_BIAS, 1, 0, 0, -8388608));
		add_row(item_row(OP_RUN, 0, 0, 0, 0, 1, -8355840));
		// weight to the input layer is dropped; input loads ignore the layer field
		add_row(item_row(OP_WEIGHT, 0, 5, 5, 12345));
		add_row(item_row(OP_INPUT, 7, 0, 63, -8388608));
		add_row(item_row(OP_INPUT, 3, 1, 0, -8388608));
		add_row(item_row(OP_INPUT, 0, 63, 0, 8388607));
		add_row(item_row(OP_WEIGHT, 1, 0, 0, 8388607));
		add_row(item_row(OP_WEIGHT, 1, 0, 1, -8388608));
		add_row(item_row(OP_WEIGHT, 7, 63, 63, 8388607));
		add_row(item_row(OP_WEIGHT, 1, 63, 63, -8388608));
		add_row(item_row(OP_BIAS, 7, 63, 0, -8388608));
		add_row(item_row(OP_BIAS, 0, 0, 0, 8388607));
		add_row(item_row(OP_BIAS, 1, 0, 0, 0));
		// count below range, oversized layer clamped to 64
		add_row(cfg_row(4'd0, lsz(0, 2) | lsz(1, 127)));
		add_row(item_row(OP_RUN, 0, 0, 0, 0));
		// count above range with an empty middle layer
		add_row(cfg_row(4'd15, lsz(0, 64) | lsz(1, 2) | lsz(3, 3) | lsz(4, 1) |
			lsz(5, 2) | lsz(6, 2) | lsz(7, 64)));
		add_row(item_row(OP_RUN, 0, 0, 0, 0));
		// empty output layer gives no output at all
		add_row(cfg_row(4'd3, lsz(0, 1) | lsz(1, 1)));
		add_row(item_row(OP_RUN, 0, 0, 0, 0));

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				program_net(plan[i].count, plan[i].sizes);
			end else begin
				send(plan[i].op, plan[i].li, plan[i].ni, plan[i].si, plan[i].val);
				if (plan[i].typed) pending_outputs[$].val = plan[i].want;
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = (ph == 0) ? 29 : (ph == 1) ? 51 : 0;
			rx_idle = (ph == 0) ? 51 : (ph == 1) ? 29 : 0;
			phase_items = items_sent;
			random_net(1'b1);
			while (items_sent - phase_items < 80) random_net(1'b0);
		end

		// largest network: eight layers of 64 with whatever the stores hold, then eight empty layers
		program_net(4'd15, {56{1'b1}});
		send(OP_RUN, 3'd0, 6'd0, 6'd0, 24'd0);
		program_net(4'd8, '0);
		send(OP_RUN, 3'd0, 6'd0, 6'd0, 24'd0);
		drain();

		$display("Covered %0d items (%0d runs), %0d outputs checked, %0d mismatches",
			items_sent, runs_sent, checked, errors);
		if (errors == 0)
			$display("tb_mlp_forward_sigmoid_top: done, clean");
		else
			$display("tb_mlp_forward_sigmoid_top: done, errors");
		$finish;
	end

endmodule

/* mlp_forward_sigmoid_top.f */
rtl/core/mfs_pkg.sv
rtl/core/mfs_front.sv
rtl/core/mfs_sigmoid.sv
rtl/core/mfs_engine.sv
rtl/core/mlp_forward_sigmoid_top.sv
verif/tb_mlp_forward_sigmoid_top.sv
